[hw/rtl/ert_pkg.sv]
package ert_pkg;
  localparam int BandMax = 64;
  localparam int CoefBits = 24;
  localparam int IdxBits = 6;
  localparam int CntBits = 7;
  localparam int MagBits = 24;
  localparam int SqBits = 48;
  localparam int EnBits = 54;
  localparam int FracBits = 17;
  localparam int NeedBits = 71;
  localparam int EnHalf = 27;
  localparam int PartBits = EnHalf + FracBits;
  localparam logic [FracBits-1:0] FracReset = 17'd64881;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_energy;
    logic add_total;
    logic init_order;
    logic rd_a;
    logic rd_b;
    logic cmp;
    logic swap_a;
    logic swap_b;
    logic add_run;
    logic mark;
    logic mark_all;
    logic clr_mask;
    logic [IdxBits-1:0] addr_a;
    logic [IdxBits-1:0] addr_b;
  } ert_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic zero_energy;
    logic reached;
  } ert_sts_t;

  function automatic logic [MagBits-1:0] mag(input logic [CoefBits-1:0] c);
    mag = c[CoefBits-1] ? (~c + 1'b1) : c;
  endfunction
endpackage

[hw/rtl/energy_retention_threshold_unit.sv]
// energy retention threshold unit
// s_axis words carry one coefficient each; tlast closes the band, and a band
// also closes after 64 words. cfg writes keep_fraction (unsigned Q1.16); the
// user must write it only while idle, the block itself does not enforce this.
// after closing, the band energy is summed, the indices are selection sorted
// by magnitude (n*(n+1)/2 compares), then the sorted order is walked until the
// kept energy reaches the target; a zero-energy band skips both and keeps all.
// the band is then sent on m_axis in arrival order, with dropped words zeroed.
// most of the time goes to the sort loop over the single-port coefficient store.
// no new word is taken until the band is out.
// reset clears control, the keep mask and sets keep_fraction to 64881.
// a stalled m_axis holds its word in the output register and pauses the block.
module energy_retention_threshold_unit import ert_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // coefficient
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // kept_value
  output logic        m_axis_tuser,   // kept
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);
  ert_cmd_t cmd;
  ert_sts_t sts;
  logic [FracBits-1:0] frac;
  logic in_fire, out_free, out_load, last_c, kept_c;
  logic [CoefBits-1:0] val_c;

  assign cfg_ready = 1'b1;
  // fraction register
  always_ff @(posedge clk) begin
    if (rst) frac <= FracReset;
    else if (cfg_valid) frac <= cfg_data;
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  ert_control u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_axis_tlast), .sts, .out_free, .cmd,
    .in_ready(s_axis_tready), .out_load, .out_last(last_c)
  );
  ert_datapath u_dp (
    .clk, .rst, .cmd, .in_coef(s_axis_tdata), .frac, .sts,
    .out_value(val_c), .out_kept(kept_c)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (out_load) begin
      m_axis_tdata <= val_c;
      m_axis_tuser <= kept_c;
      m_axis_tlast <= last_c;
    end
  end
endmodule

[hw/rtl/ert_datapath.sv]
module ert_datapath import ert_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ert_cmd_t            cmd,
  input  logic [CoefBits-1:0] in_coef,
  input  logic [FracBits-1:0] frac,
  output ert_sts_t            sts,
  output logic [CoefBits-1:0] out_value,
  output logic                out_kept
);
  logic [CoefBits-1:0] coef_mem [BandMax];
  logic [IdxBits-1:0] order_mem [BandMax];
  logic [BandMax-1:0] keep_mask;
  logic [EnBits-1:0] total_energy, running_energy;
  logic [CoefBits-1:0] coef_rd;
  logic [IdxBits-1:0] ord_a, ord_b, best_idx, best_pos;
  logic [MagBits-1:0] best_mag;
  logic [SqBits-1:0] sq;
  logic [NeedBits-1:0] need;
  logic [PartBits-1:0] need_lo, need_hi;
  logic [CoefBits-1:0] cand_mag;

  // coefficient store, one read port
  always_ff @(posedge clk) begin
    if (cmd.load) coef_mem[cmd.addr_a] <= in_coef;
    coef_rd <= coef_mem[cmd.rd_b ? ord_b : cmd.addr_a];
  end

  // order store: read two addresses, swap writes
  always_ff @(posedge clk) begin
    if (cmd.init_order) order_mem[cmd.addr_a] <= cmd.addr_a;
    else if (cmd.swap_a) order_mem[cmd.addr_a] <= best_idx;
    else if (cmd.swap_b) order_mem[best_pos] <= ord_a;
    if (cmd.rd_a) ord_a <= order_mem[cmd.addr_a];
    if (cmd.rd_b) ord_b <= order_mem[cmd.addr_b];
  end

  assign cand_mag = mag(coef_rd);

  // square, energy sums, selection tracking
  always_ff @(posedge clk) begin
    sq <= cand_mag * cand_mag;
    if (cmd.clr_energy) begin
      total_energy <= '0;
      running_energy <= '0;
    end else if (cmd.add_total) begin
      total_energy <= total_energy + EnBits'(sq);
    end else if (cmd.add_run) begin
      running_energy <= running_energy + EnBits'(sq);
    end
    // target energy in two half-width products
    need_lo <= total_energy[EnHalf-1:0] * frac;
    need_hi <= total_energy[EnBits-1:EnHalf] * frac;
    need <= (NeedBits'(need_hi) << EnHalf) + NeedBits'(need_lo);
    if (cmd.cmp) begin
      if (cmd.addr_b == cmd.addr_a || cand_mag > best_mag) begin
        best_mag <= cand_mag;
        best_idx <= ord_b;
        best_pos <= cmd.addr_b;
      end
    end
  end

  // keep mask
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_mask) keep_mask <= '0;
    else if (cmd.mark_all) keep_mask <= '1;
    else if (cmd.mark) keep_mask[ord_b] <= 1'b1;
  end

  assign sts.zero_energy = (total_energy == '0);
  assign sts.reached = NeedBits'({running_energy, 16'd0}) >= need;
  assign out_value = keep_mask[cmd.addr_a] ? coef_rd : '0;
  assign out_kept = keep_mask[cmd.addr_a];
endmodule

[hw/rtl/ert_control.sv]
module ert_control import ert_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                in_last,
  input  ert_sts_t            sts,
  input  logic                out_free,
  output ert_cmd_t            cmd,
  output logic                in_ready,
  output logic                out_load,
  output logic                out_last
);
  typedef enum logic [3:0] {
    S_LOAD, S_SUM, S_SUMW, S_CHK, S_SEL, S_SELW, S_SWAP, S_WALK, S_WALKW,
    S_TEST, S_EMIT, S_EMITW
  } state_t;
  state_t state;
  logic [CntBits-1:0] n, i, j, k;

  always_comb begin
    cmd = '0;
    cmd.addr_a = i[IdxBits-1:0];
    cmd.addr_b = j[IdxBits-1:0];
    in_ready = (state == S_LOAD);
    out_load = 1'b0;
    out_last = (i + 1'b1 == n);
    case (state)
      S_LOAD: begin
        cmd.addr_a = n[IdxBits-1:0];
        cmd.load = in_fire;
        cmd.clr_energy = 1'b1;
        cmd.clr_mask = 1'b1;
      end
      S_SUM: cmd.init_order = 1'b1;
      S_SUMW: cmd.add_total = (k == 1);
      S_SEL: begin
        cmd.rd_a = (j == i);
        cmd.rd_b = 1'b1;
      end
      S_SELW: begin
        cmd.rd_b = 1'b1;
        cmd.cmp = (k == 1);
      end
      S_SWAP: cmd.swap_a = (k == 0);
      S_WALK: cmd.rd_b = 1'b1;
      S_WALKW: cmd.rd_b = 1'b1;
      S_TEST: begin
        cmd.add_run = (k == 1);
        cmd.mark = (k == 1);
      end
      S_CHK: cmd.mark_all = sts.zero_energy && k == 3;
      S_EMIT: ;
      S_EMITW: out_load = out_free;
      default: ;
    endcase
    if (state == S_SWAP && k == 1) begin
      cmd.swap_b = 1'b1;
      cmd.addr_b = j[IdxBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      n <= '0; i <= '0; j <= '0; k <= '0;
    end else begin
      case (state)
        S_LOAD: if (in_fire) begin
          n <= n + 1'b1;
          if (in_last || n + 1'b1 == CntBits'(BandMax)) begin
            state <= S_SUM; i <= '0; k <= '0;
          end
        end
        // read each coefficient, square, accumulate
        S_SUM: begin state <= S_SUMW; k <= '0; end
        S_SUMW: begin
          k <= k + 1'b1;
          if (k == 2) begin
            if (i + 1'b1 == n) begin state <= S_CHK; k <= '0; end
            else begin i <= i + 1'b1; state <= S_SUM; end
          end else if (k == 1) ;
        end
        S_CHK: begin
          k <= k + 1'b1;
          if (k == 3) begin
            i <= '0; j <= '0; k <= '0;
            state <= sts.zero_energy ? S_EMIT : S_SEL;
          end
        end
        // selection pass: compare order[j] for j from i to n-1
        S_SEL: state <= S_SELW;
        S_SELW: begin
          k <= k + 1'b1;
          if (k == 2) begin
            k <= '0;
            if (j + 1'b1 == n) begin state <= S_SWAP; j <= '0; end
            else begin j <= j + 1'b1; state <= S_SEL; end
          end
        end
        S_SWAP: begin
          k <= k + 1'b1;
          if (k == 1) begin
            k <= '0;
            if (i + 1'b1 == n) begin i <= '0; j <= '0; state <= S_WALK; end
            else begin i <= i + 1'b1; j <= i + 1'b1; state <= S_SEL; end
          end
        end
        // walk sorted order until target energy met
        S_WALK: begin state <= S_WALKW; k <= '0; end
        S_WALKW: begin
          k <= k + 1'b1;
          if (k == 2) begin state <= S_TEST; k <= '0; end
        end
        S_TEST: begin
          k <= k + 1'b1;
          if (k == 3) begin
            k <= '0;
            if (sts.reached || j + 1'b1 == n) begin i <= '0; state <= S_EMIT; end
            else begin j <= j + 1'b1; state <= S_WALK; end
          end
        end
        // stream out in arrival order
        S_EMIT: state <= S_EMITW;
        S_EMITW: if (out_free) begin
          if (i + 1'b1 == n) begin state <= S_LOAD; n <= '0; i <= '0; end
          else begin i <= i + 1'b1; state <= S_EMIT; end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // the swap in S_SWAP uses best_pos for the second write
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_LOAD)
    else $error("ready outside load");
  assert property (@(posedge clk) disable iff (rst) out_load |-> i < n)
    else $error("emit beyond band");
  assert property (@(posedge clk) disable iff (rst) (state == S_LOAD) |-> n < CntBits'(BandMax))
    else $error("store overfull");
endmodule
